/* rtl/gpbo_pkg.sv */
// Package for the galvo path player: sizes, request and register codes,
// channel structs and the drive and offset arithmetic. Depends on nothing.
`timescale 1ns / 1ps

package gpbo_pkg;

    localparam int PATH_DEPTH  = 1024;
    localparam int ADDR_BITS   = $clog2(PATH_DEPTH);
    localparam int COORD_BITS  = 12;
    localparam int WORD_BITS   = 2 * COORD_BITS;
    localparam int LEN_BITS    = 11;
    localparam int LON_BITS    = 10;
    localparam int STEP_BITS   = 8;
    localparam int LIM_BITS    = 11;
    localparam int OFS_BITS    = 12;
    localparam int DRV_BITS    = COORD_BITS + 2;
    localparam int CENTER_BIAS = 256;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_MOVE   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PATH_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LASER_ON_INDEX = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_STEP         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_STEP         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_MAX     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_MIN     = 3'd5;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [LON_BITS-1:0]   point_index;
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_drive;
        logic [COORD_BITS-1:0] y_drive;
        logic                  laser_on;
    } t_out_item;

    typedef struct packed {
        logic                       valid;
        logic signed [OFS_BITS-1:0] x_off;
        logic signed [OFS_BITS-1:0] y_off;
        logic                       laser;
    } t_rd_meta;

    typedef struct packed {
        logic signed [OFS_BITS-1:0] off;
        logic                       rev;
    } t_bounce;

    function automatic logic [COORD_BITS-1:0] sat_drive(
        input logic [COORD_BITS-1:0]    coord,
        input logic signed [OFS_BITS-1:0] off
    );
        logic signed [DRV_BITS-1:0] v;
        v = $signed({3'b000, coord[COORD_BITS-1:1]})
            + $signed(DRV_BITS'(CENTER_BIAS))
            + DRV_BITS'(off);
        if (v < 0) begin
            return '0;
        end else if (v > $signed(DRV_BITS'({COORD_BITS{1'b1}}))) begin
            return '1;
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic t_bounce bounce(
        input logic signed [OFS_BITS-1:0]  off,
        input logic                        rev,
        input logic signed [STEP_BITS-1:0] step,
        input logic signed [LIM_BITS-1:0]  vmax,
        input logic signed [LIM_BITS-1:0]  vmin
    );
        logic signed [STEP_BITS:0]   s;
        logic signed [OFS_BITS:0]    v;
        t_bounce                     r;
        s = rev ? -(STEP_BITS+1)'(step) : (STEP_BITS+1)'(step);
        v = (OFS_BITS+1)'(off) + (OFS_BITS+1)'(s);
        r.rev = rev;
        r.off = v[OFS_BITS-1:0];
        if (v >= (OFS_BITS+1)'(vmax)) begin
            r.off = OFS_BITS'(vmax);
            r.rev = !rev;
        end else if (v <= (OFS_BITS+1)'(vmin)) begin
            r.off = OFS_BITS'(vmin);
            r.rev = !rev;
        end
        return r;
    endfunction

endpackage

/* rtl/gpbo_ram.sv */
// Simple dual-port path memory: one write port, one read port with
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module gpbo_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gpbo_seq.sv */
// Sequencer: configuration registers, play index, laser flag and bouncing
// offsets; issues path memory writes and reads. Depends on gpbo_pkg.
`timescale 1ns / 1ps

module gpbo_seq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gpbo_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [gpbo_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_acc,
    input  gpbo_pkg::t_in_item                 i_item,
    input  logic                               i_s1_take,
    output logic                               o_we,
    output logic [gpbo_pkg::ADDR_BITS-1:0]     o_waddr,
    output logic [gpbo_pkg::WORD_BITS-1:0]     o_wdata,
    output logic                               o_re,
    output logic [gpbo_pkg::ADDR_BITS-1:0]     o_raddr,
    output gpbo_pkg::t_rd_meta                 o_meta
);
    import gpbo_pkg::*;

    logic [LEN_BITS-1:0]         r_path_length;
    logic [LON_BITS-1:0]         r_laser_on_index;
    logic signed [STEP_BITS-1:0] r_x_step, r_y_step;
    logic signed [LIM_BITS-1:0]  r_offset_max, r_offset_min;

    logic [LEN_BITS-1:0]         r_play_index, n_play_index;
    logic signed [OFS_BITS-1:0]  r_x_offset, r_y_offset;
    logic                        r_x_rev, r_y_rev;
    logic                        r_laser, n_laser;
    t_rd_meta                    r_meta;

    logic [LEN_BITS-1:0] eff_len;
    logic [LEN_BITS-1:0] last_idx;
    logic                in_range;
    logic                smp_acc, mov_acc;
    t_bounce             x_b, y_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_length    <= LEN_BITS'(299);
            r_laser_on_index <= LON_BITS'(10);
            r_x_step         <= STEP_BITS'(20);
            r_y_step         <= -STEP_BITS'(24);
            r_offset_max     <= LIM_BITS'(500);
            r_offset_min     <= -LIM_BITS'(50);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATH_LENGTH:    r_path_length    <= i_cfg_data[LEN_BITS-1:0];
                CFG_LASER_ON_INDEX: r_laser_on_index <= i_cfg_data[LON_BITS-1:0];
                CFG_X_STEP:         r_x_step         <= i_cfg_data[STEP_BITS-1:0];
                CFG_Y_STEP:         r_y_step         <= i_cfg_data[STEP_BITS-1:0];
                CFG_OFFSET_MAX:     r_offset_max     <= i_cfg_data[LIM_BITS-1:0];
                CFG_OFFSET_MIN:     r_offset_min     <= i_cfg_data[LIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign smp_acc = i_acc && (i_item.req_type == REQ_SAMPLE);
    assign mov_acc = i_acc && (i_item.req_type == REQ_MOVE);

    always_comb begin
        if (r_path_length == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (r_path_length > LEN_BITS'(PATH_DEPTH)) begin
            eff_len = LEN_BITS'(PATH_DEPTH);
        end else begin
            eff_len = r_path_length;
        end
        last_idx = eff_len - LEN_BITS'(1);
        in_range = r_play_index < eff_len;
    end

    always_comb begin
        n_laser      = r_laser;
        n_play_index = r_play_index;
        if (r_play_index == LEN_BITS'(r_laser_on_index)) begin
            n_laser = 1'b1;
        end
        if (in_range) begin
            n_play_index = r_play_index + LEN_BITS'(1);
        end else begin
            n_laser = 1'b0;
        end
    end

    assign x_b = bounce(r_x_offset, r_x_rev, r_x_step, r_offset_max, r_offset_min);
    assign y_b = bounce(r_y_offset, r_y_rev, r_y_step, r_offset_max, r_offset_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_index <= '0;
            r_x_offset   <= '0;
            r_y_offset   <= '0;
            r_x_rev      <= 1'b0;
            r_y_rev      <= 1'b0;
            r_laser      <= 1'b0;
        end else if (smp_acc) begin
            r_play_index <= n_play_index;
            r_laser      <= n_laser;
        end else if (mov_acc) begin
            r_play_index <= '0;
            r_x_offset   <= x_b.off;
            r_y_offset   <= y_b.off;
            r_x_rev      <= x_b.rev;
            r_y_rev      <= y_b.rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta.valid <= 1'b0;
        end else if (smp_acc) begin
            r_meta.valid <= 1'b1;
            r_meta.x_off <= r_x_offset;
            r_meta.y_off <= r_y_offset;
            r_meta.laser <= n_laser;
        end else if (i_s1_take) begin
            r_meta.valid <= 1'b0;
        end
    end

    assign o_we    = i_acc && (i_item.req_type == REQ_LOAD);
    assign o_waddr = ADDR_BITS'(i_item.point_index);
    assign o_wdata = {i_item.point_x, i_item.point_y};
    assign o_re    = smp_acc;
    assign o_raddr = in_range ? r_play_index[ADDR_BITS-1:0] : last_idx[ADDR_BITS-1:0];
    assign o_meta  = r_meta;

endmodule

/* rtl/gpbo_drive.sv */
// Drive stage: scales the read point, adds bias and offset, saturates and
// holds the result in the output register. Depends on gpbo_pkg.
`timescale 1ns / 1ps

module gpbo_drive (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gpbo_pkg::t_rd_meta             i_meta,
    input  logic [gpbo_pkg::WORD_BITS-1:0] i_rdata,
    input  logic                           i_ready,
    output logic                           o_take,
    output logic                           o_valid,
    output gpbo_pkg::t_out_item            o_item
);
    import gpbo_pkg::*;

    logic      r_valid;
    t_out_item r_item, n_item;

    assign o_take = !r_valid || i_ready;

    always_comb begin
        n_item.x_drive  = sat_drive(i_rdata[WORD_BITS-1:COORD_BITS], i_meta.x_off);
        n_item.y_drive  = sat_drive(i_rdata[COORD_BITS-1:0], i_meta.y_off);
        n_item.laser_on = i_meta.laser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_meta.valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/galvo_path_player_bouncing_offset.sv */
// Top level of the galvo path player with bouncing offset.
// Depends on gpbo_pkg, gpbo_ram, gpbo_seq and gpbo_drive.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_item (t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One input transaction is taken per cycle while input ready is high. A sample
// tick's result passes through the path memory read register and then the
// output register. Loads and move ticks finish at acceptance.
// Input ready drops only while both the read stage and the output register
// hold a sample and the output is stalled. Reset is synchronous; the path
// memory is not cleared and is undefined until written.
`timescale 1ns / 1ps

module galvo_path_player_bouncing_offset (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  gpbo_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output gpbo_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gpbo_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [gpbo_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import gpbo_pkg::*;

    logic                 acc;
    logic                 s1_take;
    logic                 we, re;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;
    t_rd_meta             meta;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !meta.valid || s1_take;
    assign acc         = i_in_valid && o_in_ready;

    gpbo_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_item      (i_in_item),
        .i_s1_take   (s1_take),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_meta      (meta)
    );

    gpbo_ram #(
        .DEPTH (PATH_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    gpbo_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meta  (meta),
        .i_rdata (rdata),
        .i_ready (i_out_ready),
        .o_take  (s1_take),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule
